[rtl/packed_bitfield_array_unit_assert.svh]
// ============================================================================
// Packed bit-field array assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef PACKED_BITFIELD_ARRAY_UNIT_ASSERT_SVH
`define PACKED_BITFIELD_ARRAY_UNIT_ASSERT_SVH

// same-cycle implication
`define PBFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packed_bitfield_array_unit: check failed");

// next-cycle implication
`define PBFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packed_bitfield_array_unit: check failed");

`endif

[rtl/pbfa_pkg.sv]
// ============================================================================
// Packed bit-field array package
// Field widths, defaults, mode codes and the element locator record.
// ============================================================================
package pbfa_pkg;

   localparam int INDEX_BITS      = 15;
   localparam int WIDTH_BITS      = 6;
   localparam int VALUE_BITS      = 32;
   localparam int POS_BITS        = INDEX_BITS + WIDTH_BITS;
   localparam int OFF_BITS        = 6;
   localparam int WORD_BITS_DEF   = 32;
   localparam int STORE_WORDS_DEF = 1024;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(8);

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic [POS_BITS-1:0] addr;
      logic [OFF_BITS-1:0] off;
      logic                straddle;
      logic                oor;
   } loc_type;

   function automatic logic [VALUE_BITS-1:0] low_ones(input logic [WIDTH_BITS-1:0] n);
      return ~({VALUE_BITS{1'b1}} << n);
   endfunction

endpackage

[rtl/pbfa_ram.sv]
// ============================================================================
// Packed bit-field array RAM
// Generic single-port RAM with registered read data.
// ============================================================================
module pbfa_ram
   import pbfa_pkg::*;
#(
   parameter  int WIDTH     = WORD_BITS_DEF,
   parameter  int DEPTH     = STORE_WORDS_DEF / 2,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic                 write_enable,
   input  logic [WIDTH-1:0]     write_data,
   input  logic                 read_enable,
   output logic [WIDTH-1:0]     read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

[rtl/pbfa_locate.sv]
// ============================================================================
// Packed bit-field array element locator
// Three-stage pipe: bit position, reciprocal quotient, remainder correction
// and range check.
// ============================================================================
module pbfa_locate
   import pbfa_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [INDEX_BITS-1:0] index,
   input  logic [WIDTH_BITS-1:0] width,
   output logic                  loc_valid,
   output loc_type               loc
);

   localparam int K = POS_BITS;
   localparam logic [K:0]          RECIP = (K+1)'((2 ** K) / WORD_BITS);
   localparam logic [POS_BITS-1:0] DIV   = POS_BITS'(WORD_BITS);
   localparam logic [POS_BITS:0]   LIMIT = (POS_BITS+1)'(STORE_WORDS);
   localparam logic [OFF_BITS:0]   WORD_LEN = (OFF_BITS+1)'(WORD_BITS);

   logic                  v1_ff, v2_ff, loc_valid_ff;
   logic [POS_BITS-1:0]   pos_ff, pos2_ff, qest_ff;
   logic [WIDTH_BITS-1:0] w1_ff, w2_ff;
   loc_type               loc_ff;

   logic [2*POS_BITS:0]   prod;
   logic [2*POS_BITS-1:0] qd;
   logic [POS_BITS-1:0]   rem, rem_fix;
   logic                  fix;
   loc_type               loc_in;
   logic [POS_BITS:0]     last_word;

   assign prod = pos_ff * RECIP;
   assign qd   = qest_ff * DIV;

   always_comb begin
      rem              = pos2_ff - qd[POS_BITS-1:0];
      fix              = rem >= DIV;
      rem_fix          = fix ? rem - DIV : rem;
      loc_in.addr      = qest_ff + POS_BITS'(fix);
      loc_in.off       = rem_fix[OFF_BITS-1:0];
      loc_in.straddle  = ((OFF_BITS+1)'(loc_in.off) + (OFF_BITS+1)'(w2_ff)) > WORD_LEN;
      last_word        = (POS_BITS+1)'(loc_in.addr) + (POS_BITS+1)'(loc_in.straddle);
      loc_in.oor       = last_word >= LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         loc_valid_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         if (start) begin
            loc_valid_ff <= 1'b0;
         end else if (v2_ff) begin
            loc_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pos_ff <= {{WIDTH_BITS{1'b0}}, index} * {{INDEX_BITS{1'b0}}, width};
         w1_ff  <= width;
      end
      if (v1_ff) begin
         qest_ff <= prod[2*POS_BITS-1:POS_BITS];
         pos2_ff <= pos_ff;
         w2_ff   <= w1_ff;
      end
      if (v2_ff) begin
         loc_ff <= loc_in;
      end
   end

   assign loc_valid = loc_valid_ff;
   assign loc       = loc_ff;

endmodule

[rtl/packed_bitfield_array_unit.sv]
// ============================================================================
// Packed bit-field array unit
// Reads and writes elements of 1 to 32 bits packed back to back in a word
// store held in two single-port RAM banks, even and odd word addresses.
// ============================================================================
// One request is handled at a time; an in-range access passes through the
// locator pipe (index times width, reciprocal division by the word size,
// remainder fix), then the bank reads, then the merge and write-back. Both
// words of a straddling element are read and written in the same cycle, one
// per bank. Reads, and accesses that fall past the store, return one
// response; an in-range write returns none. After reset the store is cleared,
// row by row in both banks, before the first request is taken; the width
// register may be written at any time the unit is idle.
module packed_bitfield_array_unit
   import pbfa_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [WIDTH_BITS-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [INDEX_BITS-1:0] req_element_index,
   input  logic [VALUE_BITS-1:0] req_write_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic                  rsp_out_of_range
);

   localparam int EVEN_DEPTH = (STORE_WORDS + 1) / 2;
   localparam int ODD_DEPTH  = STORE_WORDS / 2;
   localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
   localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
   localparam int DW         = 2 * WORD_BITS;
   localparam int CAP        = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
   localparam logic [WIDTH_BITS-1:0] WIDTH_CAP = WIDTH_BITS'(CAP);
   localparam logic [EVEN_AW-1:0]    CLR_LAST  = EVEN_AW'(EVEN_DEPTH - 1);
   localparam logic [EVEN_AW:0]      ODD_ROWS  = (EVEN_AW+1)'(ODD_DEPTH);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOCATE = 4'b0100,
      ST_MERGE  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [WIDTH_BITS-1:0] width_ff;
   logic [EVEN_AW-1:0]    clr_row_ff;
   logic                  mode_ff;
   logic [VALUE_BITS-1:0] wmask_ff, value_ff;
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_oor_ff, rsp_oor_in;
   logic                  rsp_load;

   logic [WIDTH_BITS-1:0] w_eff;
   logic [VALUE_BITS-1:0] w_mask;
   logic                  req_fire, out_free;

   logic                  loc_valid;
   loc_type               loc;

   logic [POS_BITS:0]     addr_p1;
   logic [EVEN_AW-1:0]    even_row, even_addr;
   logic [ODD_AW-1:0]     odd_row, odd_addr;
   logic                  even_re, odd_re, even_we, odd_we;
   logic [WORD_BITS-1:0]  even_rdata, odd_rdata, even_wdata, odd_wdata;
   logic [WORD_BITS-1:0]  lo_word, hi_word;
   logic [DW-1:0]         combined, mask_win, val_win, merged;
   logic [DW+VALUE_BITS-1:0] ext, mask_ext, val_ext;
   logic [VALUE_BITS-1:0] read_val;
   logic                  issue_read, do_write;
   logic                  bank_we, write_phase;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_CAP) begin
         w_eff = WIDTH_CAP;
      end
   end

   assign w_mask    = low_ones(w_eff);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   pbfa_locate #(
      .WORD_BITS  (WORD_BITS),
      .STORE_WORDS(STORE_WORDS)
   ) u_locate (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .index    (req_element_index),
      .width    (w_eff),
      .loc_valid(loc_valid),
      .loc      (loc)
   );

   // bank rows: odd bank holds word 2r+1, even bank word 2r
   assign addr_p1  = (POS_BITS+1)'(loc.addr) + (POS_BITS+1)'(1);
   assign even_row = addr_p1[EVEN_AW:1];
   assign odd_row  = loc.addr[ODD_AW:1];

   assign lo_word  = loc.addr[0] ? odd_rdata : even_rdata;
   assign hi_word  = loc.addr[0] ? even_rdata : odd_rdata;
   assign combined = {hi_word, lo_word};

   assign ext      = {{VALUE_BITS{1'b0}}, combined} >> loc.off;
   assign read_val = ext[VALUE_BITS-1:0] & wmask_ff;
   assign mask_ext = (DW+VALUE_BITS)'(wmask_ff) << loc.off;
   assign val_ext  = (DW+VALUE_BITS)'(value_ff) << loc.off;
   assign mask_win = mask_ext[DW-1:0];
   assign val_win  = val_ext[DW-1:0];
   assign merged   = (combined & ~mask_win) | val_win;

   assign issue_read = (state_ff == ST_LOCATE) && loc_valid && !loc.oor;
   assign do_write   = (state_ff == ST_MERGE) && (mode_ff == MODE_WRITE);

   always_comb begin
      even_re    = issue_read && (!loc.addr[0] || loc.straddle);
      odd_re     = issue_read && (loc.addr[0] || loc.straddle);
      even_we    = do_write && (!loc.addr[0] || loc.straddle);
      odd_we     = do_write && (loc.addr[0] || loc.straddle);
      even_wdata = loc.addr[0] ? merged[DW-1:WORD_BITS] : merged[WORD_BITS-1:0];
      odd_wdata  = loc.addr[0] ? merged[WORD_BITS-1:0] : merged[DW-1:WORD_BITS];
      even_addr  = even_row;
      odd_addr   = odd_row;
      if (state_ff == ST_CLEAR) begin
         even_we    = 1'b1;
         odd_we     = (EVEN_AW+1)'(clr_row_ff) < ODD_ROWS;
         even_wdata = '0;
         odd_wdata  = '0;
         even_addr  = clr_row_ff;
         odd_addr   = clr_row_ff[ODD_AW-1:0];
      end
   end

   assign bank_we     = even_we || odd_we;
   assign write_phase = (state_ff == ST_CLEAR) || (state_ff == ST_MERGE);

   pbfa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(EVEN_DEPTH)
   ) u_even_ram (
      .clock       (clock),
      .addr        (even_addr),
      .write_enable(even_we),
      .write_data  (even_wdata),
      .read_enable (even_re),
      .read_data   (even_rdata)
   );

   pbfa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(ODD_DEPTH)
   ) u_odd_ram (
      .clock       (clock),
      .addr        (odd_addr),
      .write_enable(odd_we),
      .write_data  (odd_wdata),
      .read_enable (odd_re),
      .read_data   (odd_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_load     = 1'b0;
      rsp_value_in = '0;
      rsp_oor_in   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            if (loc_valid) begin
               if (!loc.oor) begin
                  state_in = ST_MERGE;
               end else if (out_free) begin
                  rsp_load   = 1'b1;
                  rsp_oor_in = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_MERGE: begin
            if (mode_ff == MODE_WRITE) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = read_val;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= WIDTH_RESET;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            width_ff <= csr_write_data;
         end
         if (state_ff == ST_CLEAR) begin
            clr_row_ff <= clr_row_ff + EVEN_AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff  <= req_mode;
         wmask_ff <= w_mask;
         value_ff <= req_write_value & w_mask;
      end
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_oor_ff   <= rsp_oor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

`include "packed_bitfield_array_unit_assert.svh"

   `PBFA_ASSERT_NOW(a_write_only_clear_or_merge, clock, reset, bank_we, write_phase)
   `PBFA_ASSERT_NOW(a_straddle_both, clock, reset, issue_read && loc.straddle, even_re && odd_re)
   `PBFA_ASSERT_NEXT(a_restart_locate, clock, reset, req_fire, state_ff == ST_LOCATE && !loc_valid)
   `PBFA_ASSERT_NEXT(a_write_no_rsp, clock, reset, do_write && !rsp_valid_ff, !rsp_valid_ff)

endmodule

[bench/tb_packed_bitfield_array_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// Packed bit-field array unit testbench
// Drives element reads and writes over a range of element widths and checks
// every response against a behavioral copy of the packed word store. Covers
// straddling elements, accesses past the end of the store, width limits,
// random traffic with idle and stall phases, and a long response hold-off.
// ============================================================================
module tb_packed_bitfield_array_unit;
   import pbfa_pkg::*;

   localparam int WORD_SIZE   = WORD_BITS_DEF;
   localparam int STORE_SIZE  = STORE_WORDS_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 20;

   typedef struct {
      logic [VALUE_BITS-1:0] read_value;
      logic                  out_of_range;
   } element_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [WIDTH_BITS-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_mode;
   logic [INDEX_BITS-1:0] req_element_index;
   logic [VALUE_BITS-1:0] req_write_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [VALUE_BITS-1:0] rsp_read_value;
   logic                  rsp_out_of_range;

   logic [WORD_SIZE-1:0]  model_store [STORE_SIZE];
   logic [WIDTH_BITS-1:0] model_width;
   element_result_type    awaited_results [$];

   int error_count;
   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold;
   int quiet_cycles;

   packed_bitfield_array_unit #(
      .WORD_BITS   (WORD_SIZE),
      .STORE_WORDS (STORE_SIZE)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_element_index (req_element_index),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned active_width();
      int unsigned w;
      w = 32'(model_width);
      if (w == 0) w = 1;
      if (w > 32) w = 32;
      if (w > WORD_SIZE) w = WORD_SIZE;
      return w;
   endfunction

   function automatic int unsigned last_fitting_index();
      int unsigned n;
      n = (STORE_SIZE * WORD_SIZE) / active_width() - 1;
      if (n > 32767) n = 32767;
      return n;
   endfunction

   task automatic predict_access(input logic mode, input logic [INDEX_BITS-1:0] index,
                                 input logic [VALUE_BITS-1:0] value);
      int unsigned        w;
      int unsigned        pos;
      int unsigned        addr;
      int unsigned        off;
      int unsigned        last_word;
      bit                 straddle;
      logic [63:0]        wmask;
      logic [63:0]        pair;
      element_result_type res;
      w         = active_width();
      wmask     = (64'd1 << w) - 64'd1;
      pos       = index * w;
      addr      = pos / WORD_SIZE;
      off       = pos % WORD_SIZE;
      straddle  = (off + w) > WORD_SIZE;
      last_word = straddle ? addr + 1 : addr;
      if (last_word >= STORE_SIZE) begin
         res.read_value   = '0;
         res.out_of_range = 1'b1;
         awaited_results.push_back(res);
      end else begin
         pair = {(straddle ? model_store[addr + 1] : 32'h0), model_store[addr]};
         if (mode == MODE_READ) begin
            pair             = (pair >> off) & wmask;
            res.read_value   = pair[31:0];
            res.out_of_range = 1'b0;
            awaited_results.push_back(res);
         end else begin
            pair = (pair & ~(wmask << off)) | (({32'h0, value} & wmask) << off);
            model_store[addr] = pair[31:0];
            if (straddle) model_store[addr + 1] = pair[63:32];
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [VALUE_BITS-1:0] got,
                                  input logic [VALUE_BITS-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Check each response transfer against the oldest expectation
   always @(posedge clock) begin
      element_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_read_value, '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_read_value !== want.read_value)
               report_mismatch("read_value", rsp_read_value, want.read_value);
            if (rsp_out_of_range !== want.out_of_range)
               report_mismatch("out_of_range", VALUE_BITS'(rsp_out_of_range),
                               VALUE_BITS'(want.out_of_range));
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when requested
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_access(input logic mode, input logic [INDEX_BITS-1:0] index,
                              input logic [VALUE_BITS-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_element_index <= index;
      req_write_value   <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_access(mode, index, value);
   endtask

   // Hold the sender until every response is back, then let the unit settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_BITS-1:0] w);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      model_width       = w;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_basic_access();
      send_access(MODE_WRITE, 15'd0, 32'hFFFF_FFFF);
      send_access(MODE_READ, 15'd0, 32'h0);
      send_access(MODE_READ, 15'd1, 32'hFFFF_FFFF);
      send_access(MODE_WRITE, 15'd4095, 32'h1234_56A5);
      send_access(MODE_READ, 15'd4095, 32'h0);
      send_access(MODE_READ, 15'd4096, 32'h0);
      send_access(MODE_WRITE, 15'd4096, 32'hFFFF_FFFF);
      send_access(MODE_WRITE, 15'd32767, 32'h0000_0000);
      send_access(MODE_READ, 15'd32767, 32'h0);
   endtask

   task automatic test_straddling();
      write_width(6'd24);
      send_access(MODE_WRITE, 15'd1, 32'hFFFF_FFFF);
      send_access(MODE_READ, 15'd1, 32'h0);
      send_access(MODE_READ, 15'd0, 32'h0);
      send_access(MODE_READ, 15'd2, 32'h0);
      send_access(MODE_WRITE, 15'd1364, 32'h00AB_CDEF);
      send_access(MODE_READ, 15'd1364, 32'h0);
      send_access(MODE_WRITE, 15'd1365, 32'h00FF_FFFF);
      write_width(6'd31);
      send_access(MODE_WRITE, 15'd5, 32'h5555_5555);
      send_access(MODE_READ, 15'd5, 32'h0);
      send_access(MODE_READ, 15'd1056, 32'h0);
   endtask

   task automatic test_width_limits();
      write_width(6'd0);
      send_access(MODE_WRITE, 15'd32767, 32'hFFFF_FFFF);
      send_access(MODE_READ, 15'd32767, 32'h0);
      send_access(MODE_READ, 15'd32766, 32'h0);
      write_width(6'd63);
      send_access(MODE_WRITE, 15'd1023, 32'hDEAD_BEEF);
      send_access(MODE_READ, 15'd1023, 32'h0);
      send_access(MODE_READ, 15'd1024, 32'h0);
      write_width(6'd32);
      send_access(MODE_READ, 15'd1023, 32'h0);
      write_width(6'd1);
      send_access(MODE_READ, 15'd32767, 32'h0);
   endtask

   task automatic send_random_access();
      int unsigned sel;
      int unsigned top;
      int unsigned index;
      sel = $urandom_range(0, 99);
      top = last_fitting_index();
      if (sel < 60) begin
         index = $urandom_range(0, (top < 63) ? top : 63);
      end else if (sel < 80) begin
         index = $urandom_range(0, top);
      end else if (sel < 90) begin
         index = top - 2 + $urandom_range(0, 4);
         if (index > 32767) index = 32767;
      end else begin
         index = $urandom_range(0, 32767);
      end
      send_access(logic'($urandom_range(0, 1)), INDEX_BITS'(index), $urandom);
   endtask

   task automatic run_random_phase(input logic [WIDTH_BITS-1:0] w, input int items,
                                   input int send_pct, input int recv_pct);
      write_width(w);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (items) send_random_access();
   endtask

   task automatic test_random_traffic();
      run_random_phase(6'd8, 100, 0, 0);
      run_random_phase(6'd13, 100, 56, 0);
      run_random_phase(6'd32, 100, 0, 56);
      run_random_phase(6'd1, 100, 16, 16);
      repeat (5) begin
         run_random_phase(WIDTH_BITS'($urandom_range(0, 63)), 20, 16, 16);
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      write_width(6'd8);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      rsp_hold       = 300;
      repeat (30) begin
         send_access(MODE_READ, INDEX_BITS'($urandom_range(0, 63)), $urandom);
      end
      drain_results();
   endtask

   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      req_valid         = 1'b0;
      req_mode          = MODE_READ;
      req_element_index = '0;
      req_write_value   = '0;
      rsp_ready         = 1'b0;
      error_count       = 0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      rsp_hold          = 0;
      quiet_cycles      = 0;
      model_width       = WIDTH_RESET;
      foreach (model_store[i]) model_store[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_access();
      test_straddling();
      test_width_limits();
      test_backpressure();
      test_random_traffic();

      drain_results();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[packed_bitfield_array_unit.f]
+incdir+rtl
rtl/pbfa_pkg.sv
rtl/pbfa_ram.sv
rtl/pbfa_locate.sv
rtl/packed_bitfield_array_unit.sv
bench/tb_packed_bitfield_array_unit.sv
